### hdl/mrw_pkg.sv
// Shared types, constants and helpers for the Miller-Rabin witness test block.
package mrw_pkg;

    // Operand width of the modular arithmetic.
    localparam int NUM_WIDTH = 32;
    // Width of the input fields on the item channel.
    localparam int IN_WIDTH = 32;
    // Width of the squaring counter; it holds up to NUM_WIDTH - 1.
    localparam int S_WIDTH = $clog2(NUM_WIDTH);

    // Verdict codes carried by a result item.
    typedef enum logic [1:0] {
        VERDICT_PRIME     = 2'd0,
        VERDICT_COMPOSITE = 2'd1,
        VERDICT_BAD       = 2'd2
    } t_verdict;

    // Control from the sequencer to the modular multiplier.
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    // Status from the modular multiplier back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

    // Fit an input field to the operand width: truncate or zero-extend.
    function automatic logic [NUM_WIDTH-1:0] fit_operand(input logic [IN_WIDTH-1:0] v);
        logic [NUM_WIDTH+IN_WIDTH-1:0] wide;
        wide = {{NUM_WIDTH{1'b0}}, v};
        return wide[NUM_WIDTH-1:0];
    endfunction

endpackage

### hdl/mrw_in_if.sv
// Item channel that carries a candidate and a witness into the block.
interface mrw_in_if;
    import mrw_pkg::*;

    logic                valid;
    logic                ready;
    logic [IN_WIDTH-1:0] candidate;
    logic [IN_WIDTH-1:0] witness;

    modport source (output valid, output candidate, output witness, input ready);
    modport sink   (input valid, input candidate, input witness, output ready);
endinterface

### hdl/mrw_out_if.sv
// Item channel that carries a verdict out of the block.
interface mrw_out_if;
    import mrw_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

### hdl/mrw_mulmod.sv
// Iterative shift-and-add modular multiplier, one multiplier bit per cycle.
module mrw_mulmod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mrw_pkg::t_mul_ctl               i_ctl,
    input  logic [mrw_pkg::NUM_WIDTH-1:0]   i_x,
    input  logic [mrw_pkg::NUM_WIDTH-1:0]   i_y,
    input  logic [mrw_pkg::NUM_WIDTH-1:0]   i_m,
    output mrw_pkg::t_mul_sts               o_sts,
    output logic [mrw_pkg::NUM_WIDTH-1:0]   o_product
);
    import mrw_pkg::*;

    // (x + y) mod m for x, y below m, without leaving the operand width.
    function automatic logic [NUM_WIDTH-1:0] add_mod(
        input logic [NUM_WIDTH-1:0] x,
        input logic [NUM_WIDTH-1:0] y,
        input logic [NUM_WIDTH-1:0] m
    );
        logic [NUM_WIDTH-1:0] room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    logic                 r_busy;
    logic                 r_done;
    logic [NUM_WIDTH-1:0] r_acc;
    logic [NUM_WIDTH-1:0] r_x;
    logic [NUM_WIDTH-1:0] r_y;
    logic [NUM_WIDTH-1:0] r_m;
    logic [NUM_WIDTH-1:0] n_acc;
    logic [NUM_WIDTH-1:0] n_x;

    // One step: add the multiplicand when the current bit is set, and double the multiplicand.
    always_comb begin
        n_acc = r_y[0] ? add_mod(r_acc, r_x, r_m) : r_acc;
        n_x   = add_mod(r_x, r_x, r_m);
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_y == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy && (r_y != '0)) begin
            r_acc <= n_acc;
            r_x   <= n_x;
            r_y   <= r_y >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule

### hdl/miller_rabin_witness_test.sv
// Top level of the Miller-Rabin witness test: sequencer around one modular multiplier.
//
// Each item carries an odd candidate n and a witness a and yields one verdict:
// probably prime, composite, or bad input (n even or below five, or a outside
// 2 to n-2). The block takes one item at a time and drops ready until the verdict
// is loaded into the output register; a finished verdict may wait there while the
// next item is accepted. The time an item takes is set by the single shift-and-add modular
// multiplier, which steps through the bits of its second operand until none is left.
// With n-1 = d * 2^s, an item first strips s factors of two from n-1, then needs
// up to two products per bit of d and up to s-1 squarings; for 32-bit operands
// the worst case is at most 61 products. Bad input goes from S_CHECK straight to
// S_DONE without starting the multiplier.
module miller_rabin_witness_test (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrw_in_if.sink    i_item,
    mrw_out_if.source o_result
);
    import mrw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_POW_TEST,
        S_POW_MUL,
        S_POW_SQR,
        S_X_TEST,
        S_SQR_TEST,
        S_SQR,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_a;
    logic [NUM_WIDTH-1:0] r_nm1;
    logic [NUM_WIDTH-1:0] r_d;
    logic [NUM_WIDTH-1:0] r_e;
    logic [NUM_WIDTH-1:0] r_acc;
    logic [NUM_WIDTH-1:0] r_b;
    logic [S_WIDTH-1:0]   r_s;
    logic [S_WIDTH-1:0]   r_cnt;
    t_verdict             r_result;
    logic                 r_out_valid;
    t_verdict             r_verdict;
    t_mul_ctl             r_mul_ctl;
    logic [NUM_WIDTH-1:0] r_mx;
    logic [NUM_WIDTH-1:0] r_my;

    t_mul_sts             w_mul_sts;
    logic [NUM_WIDTH-1:0] w_product;
    logic                 w_in_take;
    logic                 w_out_take;
    logic                 w_bad;

    assign w_in_take  = i_item.valid && i_item.ready;
    assign w_out_take = o_result.valid && o_result.ready;

    // Input screening: odd candidate of at least five, witness in 2 .. n-2.
    assign w_bad = !r_n[0] || (r_n < NUM_WIDTH'(5)) || (r_a < NUM_WIDTH'(2))
                   || (r_a > (r_n - NUM_WIDTH'(2)));

    // The shared modular multiplier; the modulus is always the candidate.
    mrw_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_mul_ctl),
        .i_x       (r_mx),
        .i_y       (r_my),
        .i_m       (r_n),
        .o_sts     (w_mul_sts),
        .o_product (w_product)
    );

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_mul_ctl.start <= 1'b0;
        end else begin
            r_mul_ctl.start <= 1'b0;
            // The output register empties when its item is taken, unless a new
            // verdict is loaded in the same cycle.
            if (w_out_take && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_n     <= fit_operand(i_item.candidate);
                        r_a     <= fit_operand(i_item.witness);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_bad) begin
                        r_result <= VERDICT_BAD;
                        r_state  <= S_DONE;
                    end else begin
                        r_nm1   <= r_n - NUM_WIDTH'(1);
                        r_d     <= r_n - NUM_WIDTH'(1);
                        r_s     <= '0;
                        r_state <= S_SPLIT;
                    end
                end
                // Strip factors of two from n-1, one per cycle.
                S_SPLIT: begin
                    if (!r_d[0]) begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + S_WIDTH'(1);
                    end else begin
                        r_e     <= r_d;
                        r_acc   <= NUM_WIDTH'(1);
                        r_b     <= r_a;
                        r_state <= S_POW_TEST;
                    end
                end
                // Square-and-multiply over the bits of d, lowest first.
                S_POW_TEST: begin
                    if (r_e == '0) begin
                        r_state <= S_X_TEST;
                    end else if (r_e[0]) begin
                        r_mx            <= r_acc;
                        r_my            <= r_b;
                        r_mul_ctl.start <= 1'b1;
                        r_state         <= S_POW_MUL;
                    end else begin
                        r_mx            <= r_b;
                        r_my            <= r_b;
                        r_mul_ctl.start <= 1'b1;
                        r_state         <= S_POW_SQR;
                    end
                end
                S_POW_MUL: begin
                    if (w_mul_sts.done) begin
                        r_acc <= w_product;
                        if ((r_e >> 1) == '0) begin
                            // Last bit: the final squaring of the base is not needed.
                            r_e     <= '0;
                            r_state <= S_POW_TEST;
                        end else begin
                            r_mx            <= r_b;
                            r_my            <= r_b;
                            r_mul_ctl.start <= 1'b1;
                            r_state         <= S_POW_SQR;
                        end
                    end
                end
                S_POW_SQR: begin
                    if (w_mul_sts.done) begin
                        r_b     <= w_product;
                        r_e     <= r_e >> 1;
                        r_state <= S_POW_TEST;
                    end
                end
                // First look at x = a^d mod n.
                S_X_TEST: begin
                    if ((r_acc == NUM_WIDTH'(1)) || (r_acc == r_nm1)) begin
                        r_result <= VERDICT_PRIME;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt   <= r_s - S_WIDTH'(1);
                        r_state <= S_SQR_TEST;
                    end
                end
                // Up to s-1 further squarings, looking for n-1.
                S_SQR_TEST: begin
                    if (r_cnt == '0) begin
                        r_result <= VERDICT_COMPOSITE;
                        r_state  <= S_DONE;
                    end else begin
                        r_mx            <= r_acc;
                        r_my            <= r_acc;
                        r_mul_ctl.start <= 1'b1;
                        r_state         <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_mul_sts.done) begin
                        r_acc <= w_product;
                        r_cnt <= r_cnt - S_WIDTH'(1);
                        if (w_product == r_nm1) begin
                            r_result <= VERDICT_PRIME;
                            r_state  <= S_DONE;
                        end else if (w_product == NUM_WIDTH'(1)) begin
                            r_result <= VERDICT_COMPOSITE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SQR_TEST;
                        end
                    end
                end
                // Hand the verdict to the output register once it is free.
                S_DONE: begin
                    if (!r_out_valid || w_out_take) begin
                        r_out_valid <= 1'b1;
                        r_verdict   <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.verdict = r_verdict;

    // A new product is never started while the multiplier is still working.
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_ctl.start |-> !w_mul_sts.busy)
        else $error("multiplier started while busy");

    // Power loop operands stay reduced modulo the candidate.
    a_pow_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POW_TEST) |-> ((r_acc < r_n) && (r_b < r_n)))
        else $error("power operands not reduced");

    // Splitting only runs on a nonzero value, so it always ends.
    a_split_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_d != '0))
        else $error("split of zero");

    // A multiplier result is only awaited while a product is pending.
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_sts.done |-> ((r_state == S_POW_MUL) || (r_state == S_POW_SQR)
                            || (r_state == S_SQR)))
        else $error("unexpected multiplier result");

endmodule
